// ===== rtl/binary_trie_max_xor_unit_defines.svh =====
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit_defines.svh
// Assertion macros shared by the trie max-xor RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_TRIE_MAX_XOR_UNIT_DEFINES_SVH
`define BINARY_TRIE_MAX_XOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BXOR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BXOR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bxor_pkg.sv =====
// ----------------------------------------------------------------------------
// bxor_pkg
// Command and status types between the trie controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bxor_pkg;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;         // accept a beat: latch value, read root
    logic ins_step;     // insert walk: evaluate one level
    logic alloc_write;  // write one link, allocate one node
    logic qry_start;    // restart at root for the query walk
    logic qry_step;     // query walk: evaluate one level
    logic finish;       // update running max, raise strobe
  } bxor_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic lvl_last;     // walking level zero
    logic ins_hit;      // child on the value's bit exists
    logic fits;         // missing levels fit in the node store
    logic qry_hit;      // some child exists for the query step
  } bxor_sts_t;

endpackage

`default_nettype wire

// ===== rtl/bxor_ctrl.sv =====
// ----------------------------------------------------------------------------
// bxor_ctrl
// Sequencer for insert walk, node allocation and query walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bxor_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire bxor_pkg::bxor_sts_t sts,
  output bxor_pkg::bxor_cmd_t      cmd
);
  import bxor_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_INS   = 2'd1;
  localparam logic [1:0] S_ALLOC = 2'd2;
  localparam logic [1:0] S_QRY   = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (sts.ins_hit) begin
          if (sts.lvl_last) begin
            cmd.qry_start = 1'b1;
            state_nxt     = S_QRY;
          end
        end else if (sts.fits) begin
          state_nxt = S_ALLOC;
        end else begin
          cmd.qry_start = 1'b1;
          state_nxt     = S_QRY;
        end
      end
      S_ALLOC: begin
        cmd.alloc_write = 1'b1;
        if (sts.lvl_last) begin
          cmd.qry_start = 1'b1;
          state_nxt     = S_QRY;
        end
      end
      S_QRY: begin
        cmd.qry_step = 1'b1;
        if (!sts.qry_hit || sts.lvl_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/bxor_dp.sv =====
// ----------------------------------------------------------------------------
// bxor_dp
// Trie datapath: child-link memory, walk registers, running maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bxor_dp #(
  parameter int VALUE_BITS = 31,
  parameter int NODE_COUNT = 32768
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bxor_pkg::bxor_cmd_t   cmd,
  output bxor_pkg::bxor_sts_t        sts,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  output logic [VALUE_BITS-1:0]      out_best_xor,
  output logic                       out_full_res
);
  import bxor_pkg::*;

  localparam int LW  = $clog2(NODE_COUNT);  // link / node index width
  localparam int EW  = 2 * LW;              // entry: {child1, child0}
  localparam int CW  = LW + 1;              // room check width
  localparam int LVW = $clog2(VALUE_BITS);

  // Child-link store; an entry is valid once its node is allocated.
  logic [EW-1:0] mem [NODE_COUNT];
  logic [EW-1:0] rd_data_r;
  logic [LW-1:0] rd_addr;

  logic [VALUE_BITS-1:0] value_r;
  logic [VALUE_BITS-1:0] x_r, x_nxt;
  logic [VALUE_BITS-1:0] best_r;
  logic [LW-1:0]         node_r, node_nxt;
  logic [LW-1:0]         nodes_used_r;
  logic [EW-1:0]         ent_r;
  logic [LVW-1:0]        lvl_r, lvl_nxt;
  logic                  full_r;
  logic                  strobe_r;

  logic [EW-1:0] eff;
  logic          bit_b;
  logic [LW-1:0] link_same, link_opp, qry_next, new_node;
  logic [EW-1:0] wr_entry;
  logic [CW-1:0] need;

  // Before the first insert the root entry has never been written.
  assign eff       = (nodes_used_r == '0) ? '0 : rd_data_r;
  assign bit_b     = value_r[lvl_r];
  assign link_same = bit_b ? eff[EW-1:LW] : eff[LW-1:0];
  assign link_opp  = bit_b ? eff[LW-1:0]  : eff[EW-1:LW];
  assign qry_next  = (link_opp != '0) ? link_opp : link_same;
  assign new_node  = nodes_used_r + LW'(1);
  assign wr_entry  = bit_b ? {new_node, ent_r[LW-1:0]} : {ent_r[EW-1:LW], new_node};
  assign need      = {1'b0, nodes_used_r} + CW'(lvl_r) + CW'(1);
  assign x_nxt     = {x_r[VALUE_BITS-2:0], (link_opp != '0)};

  assign sts.lvl_last = (lvl_r == '0);
  assign sts.ins_hit  = (link_same != '0);
  assign sts.fits     = (need <= CW'(NODE_COUNT - 1));
  assign sts.qry_hit  = (link_same != '0) || (link_opp != '0);

  always_comb begin
    rd_addr  = node_r;
    node_nxt = node_r;
    lvl_nxt  = lvl_r;
    if (cmd.load || cmd.qry_start) begin
      rd_addr  = '0;
      node_nxt = '0;
      lvl_nxt  = LVW'(VALUE_BITS - 1);
    end else if (cmd.ins_step && sts.ins_hit) begin
      rd_addr  = link_same;
      node_nxt = link_same;
      lvl_nxt  = lvl_r - LVW'(1);
    end else if (cmd.alloc_write) begin
      node_nxt = new_node;
      lvl_nxt  = lvl_r - LVW'(1);
    end else if (cmd.qry_step) begin
      rd_addr  = qry_next;
      node_nxt = qry_next;
      lvl_nxt  = lvl_r - LVW'(1);
    end
  end

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.alloc_write) begin
      mem[node_r] <= wr_entry;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    lvl_r  <= lvl_nxt;
    if (cmd.load) begin
      value_r <= in_value;
    end
    if (cmd.qry_start) begin
      x_r <= '0;
    end else if (cmd.qry_step) begin
      x_r <= x_nxt;
    end
    if (cmd.alloc_write) begin
      ent_r <= '0;  // fresh node below: both links empty
    end else if (cmd.ins_step && !sts.ins_hit) begin
      ent_r <= eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_used_r <= '0;
      best_r       <= '0;
      full_r       <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      strobe_r <= cmd.finish;
      if (cmd.alloc_write) begin
        nodes_used_r <= new_node;
      end
      if (cmd.load) begin
        full_r <= 1'b0;
      end else if (cmd.ins_step && !sts.ins_hit && !sts.fits) begin
        full_r <= 1'b1;
      end
      // Full path walked: compare against the running max.
      if (cmd.finish && sts.qry_hit && (x_nxt > best_r)) begin
        best_r <= x_nxt;
      end
    end
  end

  assign out_valid    = strobe_r;
  assign out_best_xor = best_r;
  assign out_full_res = full_r;

endmodule

`default_nettype wire

// ===== rtl/binary_trie_max_xor_unit.sv =====
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit
// Running maximum XOR over a value stream, using a binary trie in memory.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                    Handshake
//  -------  ---------------------------------------  ---------------------------
//  input    in_value                                 start && !busy takes a beat
//  result   out_best_xor, out_full_res               out_valid, one cycle, no stall
//
// Walk: after the accept edge the insert walk reads one trie level per
// cycle until a link is missing, then writes one new node per cycle (no
// node when the store is full). The query walk then reads one level per
// cycle, paced by the single read port of the link memory. The result
// strobe rises at the edge where busy falls; a new start may be given in
// that strobe cycle.
// Reset: synchronous, rst_n low. The link memory needs no clearing pass:
// the root reads as empty until the first insert, and a new node's entry is
// written in the cycle after it is allocated, before any walk reads it;
// leaf entries are never used.
// The receiver cannot stall; each result beat lasts exactly one cycle.
//
`timescale 1ns / 1ps
`default_nettype none
`include "binary_trie_max_xor_unit_defines.svh"

module binary_trie_max_xor_unit #(
  parameter int VALUE_BITS = 31,
  parameter int NODE_COUNT = 32768
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  output logic [VALUE_BITS-1:0]      out_best_xor,
  output logic                       out_full_res
);
  import bxor_pkg::*;

  bxor_cmd_t cmd;
  bxor_sts_t sts;

  // Sequencer: idle, insert walk, allocate, query walk.
  bxor_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Link memory, walk registers, node count and running maximum.
  bxor_dp #(
    .VALUE_BITS (VALUE_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_best_xor (out_best_xor),
    .out_full_res (out_full_res)
  );

  // An accepted beat starts the walk right away.
  `BXOR_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")
  // The result strobe only appears once the walk is over.
  `BXOR_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "strobe while busy")
  // Each finished item yields exactly one result beat.
  `BXOR_ASSERT_NXT(a_finish_strobe, cmd.finish, out_valid, "finish without strobe")
  `BXOR_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "strobe longer than one cycle")

endmodule

`default_nettype wire

// ===== verif/tb_binary_trie_max_xor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_trie_max_xor_unit
// Self-checking bench for the trie running max-XOR unit.
// A driver pushes 31-bit values from a backlog as start/busy command beats.
// A trie model updated on every accepted beat predicts best XOR and the
// store-full flag. A monitor checks each result strobe against the oldest
// prediction. The run walks from narrow values through a node-store fill
// into the full store, then closes on all-ones values and a zero.
// ----------------------------------------------------------------------------

module tb_binary_trie_max_xor_unit;

  localparam int VBITS = 31;
  localparam int NODES = 32768;
  // Enough cycles for one insert plus one query walk, with margin.
  localparam int DRAIN_CYCLES = 100;

  // One expected result beat.
  typedef struct packed {
    logic [VBITS-1:0] best_xor;
    logic             full_res;
  } trie_result_t;

  // Every input has a known value from time zero.
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [VBITS-1:0] in_value = '0;
  wire              busy;
  wire              out_valid;
  wire  [VBITS-1:0] out_best_xor;
  wire              out_full_res;

  binary_trie_max_xor_unit #(
    .VALUE_BITS(VBITS),
    .NODE_COUNT(NODES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_best_xor(out_best_xor),
    .out_full_res(out_full_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Trie model. Node 0 is the root; a link of 0 means no child, since the
  // root is never a child. Nodes are handed out in order, 1 upward.
  // --------------------------------------------------------------------------
  int               trie_link [NODES][2];
  int               nodes_used = 0;
  logic [VBITS-1:0] best_seen = '0;
  trie_result_t     max_xor_due [$];

  function automatic void trie_advance(input logic [VBITS-1:0] v);
    int           lvl;
    int           node;
    int           missing;
    bit           fits;
    bit           stuck;
    logic [VBITS-1:0] x;
    trie_result_t r;
    // Find how many levels are missing on the value's path.
    node = 0;
    missing = 0;
    for (lvl = VBITS - 1; lvl >= 0 && missing == 0; lvl--) begin
      if (trie_link[node][v[lvl]] == 0) missing = lvl + 1;
      else node = trie_link[node][v[lvl]];
    end
    // All-or-nothing insert: no partial path is left when the store is short.
    fits = (nodes_used + missing <= NODES - 1);
    if (fits) begin
      node = 0;
      for (lvl = VBITS - 1; lvl >= 0; lvl--) begin
        if (trie_link[node][v[lvl]] == 0) begin
          nodes_used++;
          trie_link[node][v[lvl]] = nodes_used;
        end
        node = trie_link[node][v[lvl]];
      end
    end
    // Query runs even when the insert was refused; take the opposite bit
    // whenever that child exists, and rebuild the XOR from the path.
    node = 0;
    x = '0;
    stuck = 1'b0;
    for (lvl = VBITS - 1; lvl >= 0 && !stuck; lvl--) begin
      if (trie_link[node][!v[lvl]] != 0) begin
        x[lvl] = 1'b1;
        node = trie_link[node][!v[lvl]];
      end else if (trie_link[node][v[lvl]] != 0) begin
        node = trie_link[node][v[lvl]];
      end else begin
        stuck = 1'b1;
      end
    end
    // A dead-end walk leaves the running max alone.
    if (!stuck && x > best_seen) best_seen = x;
    r.best_xor = best_seen;
    r.full_res = !fits;
    max_xor_due.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus backlog and value history (history feeds near-duplicates).
  // --------------------------------------------------------------------------
  logic [VBITS-1:0] value_backlog [$];
  logic [VBITS-1:0] value_history [$];
  int               beats_queued = 0;
  int               beats_taken = 0;
  int               fail_count = 0;
  // Idle burst odds for the driver: 0 means never, else 1 in idle_odds.
  int               idle_odds = 0;

  task automatic queue_beat(input logic [VBITS-1:0] v);
    value_backlog.push_back(v);
    value_history.push_back(v);
    beats_queued++;
  endtask

  // Fresh value, near-duplicate (low k bits redrawn) or exact duplicate,
  // all cut to the given width.
  function automatic logic [VBITS-1:0] make_value(input int width, input int fresh_pct,
                                                  input int max_k);
    int               roll;
    int               k;
    logic [VBITS-1:0] wmask;
    logic [VBITS-1:0] kmask;
    logic [VBITS-1:0] base;
    logic [31:0]      noise;
    wmask = 31'h7FFF_FFFF >> (VBITS - width);
    roll = $urandom_range(0, 99);
    noise = $urandom;
    if (value_history.size() == 0 || roll < fresh_pct) return noise[VBITS-1:0] & wmask;
    base = value_history[$urandom_range(0, value_history.size() - 1)];
    if (roll < fresh_pct + (100 - fresh_pct) * 3 / 4) begin
      k = $urandom_range(1, max_k);
      kmask = 31'h7FFF_FFFF >> (VBITS - k);
      base = (base & ~kmask) | (noise[VBITS-1:0] & kmask);
    end
    return base & wmask;
  endfunction

  // Wait until every queued beat is taken and every result has come back.
  task automatic drain();
    while (beats_taken != beats_queued || max_xor_due.size() != 0) @(posedge clk);
  endtask

  task automatic pick_idle();
    case ($urandom_range(0, 2))
      0: idle_odds = 0;
      1: idle_odds = 3;
      default: idle_odds = 8;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver. A beat goes in at an edge with start high and busy low; start
  // stays up while busy holds it off. Idle bursts either count from the
  // accept edge (gap lands inside the walk) or only once busy drops (gap
  // lands after the result).
  // --------------------------------------------------------------------------
  int idle_left = 0;
  bit idle_after_done = 1'b0;

  always @(posedge clk) begin
    logic [31:0] noise;
    noise = $urandom;
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        trie_advance(in_value);
        beats_taken++;
      end
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          if (!(idle_after_done && busy)) idle_left--;
          start <= 1'b0;
          // Junk on the data port while start is low must be ignored.
          in_value <= noise[VBITS-1:0];
        end else if (value_backlog.size() > 0 && idle_odds != 0 &&
                     $urandom_range(1, idle_odds) == 1) begin
          idle_left = $urandom_range(1, 13);
          idle_after_done = $urandom_range(0, 1);
          start <= 1'b0;
        end else if (value_backlog.size() > 0) begin
          start <= 1'b1;
          in_value <= value_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Results last one cycle and cannot be held off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    trie_result_t want;
    if (rst_n && out_valid) begin
      if (max_xor_due.size() == 0) begin
        $display("%0t: result beat with nothing expected: best_xor %h full_res %b",
                 $time, out_best_xor, out_full_res);
        fail_count++;
      end else begin
        want = max_xor_due.pop_front();
        if (out_best_xor !== want.best_xor) begin
          $display("%0t: best_xor expected %h actual %h", $time, want.best_xor, out_best_xor);
          fail_count++;
        end
        if (out_full_res !== want.full_res) begin
          $display("%0t: full_res expected %b actual %b", $time, want.full_res, out_full_res);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan.
  // --------------------------------------------------------------------------
  initial begin
    int i;
    int chunk;
    int fill_count;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Opening: first insert into an empty trie, exact duplicates, and
    // small values that force both the opposite-bit and same-bit steps.
    // Bit 30 stays clear so the running max keeps moving for a while.
    idle_odds = 4;
    queue_beat(31'd0);  queue_beat(31'd0);  queue_beat(31'd1);  queue_beat(31'd1);
    queue_beat(31'd2);  queue_beat(31'd3);  queue_beat(31'd4);  queue_beat(31'd7);
    queue_beat(31'd6);  queue_beat(31'd5);  queue_beat(31'd8);  queue_beat(31'd15);

    // Widening values, 4 up to 30 bits, so best_xor climbs step by step.
    for (i = 0; i < 150; i++) begin
      if (i % 50 == 0) begin
        drain();
        pick_idle();
      end
      queue_beat(make_value(4 + i * 27 / 150, 60, 8));
    end

    // Fill the node store with fresh full-width values. Chunks are
    // sized from the model's node count so that no insert is refused yet.
    drain();
    fill_count = 0;
    while (NODES - 1 - nodes_used > 64 && fill_count < 1800) begin
      chunk = (NODES - 1 - nodes_used) / 31;
      if (chunk > 40) chunk = 40;
      pick_idle();
      repeat (chunk) queue_beat(make_value(VBITS, 100, 6));
      fill_count += chunk;
      drain();
    end

    // Near-full and full store: short new tails use up the last nodes
    // (hitting an exact fit), longer ones are refused, duplicates still fit.
    for (i = 0; i < 60; i++) begin
      if (i % 20 == 0) begin
        drain();
        pick_idle();
      end
      queue_beat(make_value(VBITS, 10, 10));
    end

    // Final stretch back to back, no idling.
    drain();
    idle_odds = 0;
    repeat (40) queue_beat(make_value(VBITS, 10, 4));
    // All ones against the stored zero: best_xor reaches its top value
    // even when the insert itself is refused.
    queue_beat(31'h7FFF_FFFF);
    queue_beat(31'h7FFF_FFFF);
    queue_beat(31'd0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS binary_trie_max_xor_unit");
    end else begin
      $display("FAIL binary_trie_max_xor_unit");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAIL binary_trie_max_xor_unit");
    $finish;
  end

endmodule
